// ===== rtl/psc_pkg.sv =====
`default_nettype none

package psc_pkg;

  localparam int TIME_W  = 48;
  localparam int TAC_W   = 15;
  localparam int CH_W    = 7;
  localparam int SLOT_W  = 3;
  localparam int MODE_W  = 4;
  localparam int ROUTE_W = 64;
  localparam int LINE_W  = 16;
  localparam int FRAME_W = 16;
  localparam int POS_W   = 32;
  localparam int CFG_W   = 32;
  localparam int CFG_IDX_W = 3;
  localparam int MPOS_W  = 3;

  localparam logic [CH_W-1:0] CH_LINE_START = 7'd65;
  localparam logic [CH_W-1:0] CH_LINE_END   = 7'd66;
  localparam logic [CH_W-1:0] CH_FRAME      = 7'd68;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SLOTS_IN_USE = 3'd0,
    CFG_MODE_COUNT   = 3'd1,
    CFG_MODE_LIST    = 3'd2,
    CFG_POS_SCALE    = 3'd3,
    CFG_LINE_STEP    = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    logic [3:0]       slots_in_use;
    logic [3:0]       mode_count;
    logic [CFG_W-1:0] mode_list;
    logic [CFG_W-1:0] pos_scale;
    logic [CFG_W-1:0] line_step;
  } cfg_t;

  typedef struct packed {
    logic               scanning;
    logic [TIME_W-1:0]  line_start_time;
    logic [LINE_W-1:0]  line_number;
    logic [FRAME_W-1:0] frame_number;
    logic [MODE_W-1:0]  active_mode;
  } scan_t;

  typedef struct packed {
    logic [TAC_W-1:0]   tac_low;
    logic [TAC_W-1:0]   tac_high;
    logic [TIME_W-1:0]  time_low;
    logic [TIME_W-1:0]  time_high;
    logic [MODE_W-1:0]  mode;
    logic [ROUTE_W-1:0] routes;
  } slot_entry_t;

  typedef struct packed {
    logic [SLOT_W-1:0]  slot;
    logic [TAC_W-1:0]   tac;
    logic [TIME_W-1:0]  rec_time;
    logic [CH_W-1:0]    channel;
    logic [TIME_W-1:0]  record;
    logic [TIME_W-1:0]  diff;
    logic               before_start;
    logic [LINE_W-1:0]  line_number;
    logic [FRAME_W-1:0] frame;
  } pos_req_t;

endpackage

`default_nettype wire

// ===== rtl/psc_if.sv =====
`default_nettype none

interface psc_in_if;
  logic        valid;
  logic        ready;
  logic        func;
  logic [14:0] rec_tac;
  logic [47:0] rec_time;
  logic [6:0]  rec_channel;
  logic [2:0]  slot_index;
  logic [14:0] new_tac_min;
  logic [14:0] new_tac_max;
  logic [47:0] new_time_min;
  logic [47:0] new_time_max;
  logic [3:0]  new_mode_id;
  logic [63:0] new_route_mask;

  modport source (
    output valid, func, rec_tac, rec_time, rec_channel, slot_index, new_tac_min,
           new_tac_max, new_time_min, new_time_max, new_mode_id, new_route_mask,
    input  ready
  );
  modport sink (
    input  valid, func, rec_tac, rec_time, rec_channel, slot_index, new_tac_min,
           new_tac_max, new_time_min, new_time_max, new_mode_id, new_route_mask,
    output ready
  );
endinterface

interface psc_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  out_slot;
  logic [14:0] out_tac;
  logic [47:0] out_time;
  logic [6:0]  out_channel;
  logic [47:0] out_record;
  logic [31:0] x_pos;
  logic [31:0] y_pos;
  logic [15:0] out_frame;

  modport source (
    output valid, out_slot, out_tac, out_time, out_channel, out_record, x_pos, y_pos,
           out_frame,
    input  ready
  );
  modport sink (
    input  valid, out_slot, out_tac, out_time, out_channel, out_record, x_pos, y_pos,
           out_frame,
    output ready
  );
endinterface

`default_nettype wire

// ===== rtl/psc_scan_state.sv =====
`default_nettype none

module psc_scan_state #(
  parameter int MODES = 8
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          rec_fire,
  input  wire logic [psc_pkg::CH_W-1:0]      rec_channel,
  input  wire logic [psc_pkg::TIME_W-1:0]    rec_time,
  input  wire psc_pkg::cfg_t                 cfg,
  output psc_pkg::scan_t                     scan,
  output logic [psc_pkg::TIME_W-1:0]         record
);

  psc_pkg::scan_t scan_r, scan_nxt;
  logic [psc_pkg::TIME_W-1:0] record_r, record_nxt;

  // One counter per possible mode count k+1 tracks line_number mod (k+1).
  logic [psc_pkg::MPOS_W-1:0] mod_cnt_r   [MODES];
  logic [psc_pkg::MPOS_W-1:0] mod_cnt_nxt [MODES];
  logic [psc_pkg::MPOS_W-1:0] mod_cnt_inc [MODES];

  logic [3:0]                 mode_eff;
  logic                       line_wrap;
  logic [psc_pkg::MPOS_W-1:0] mode_pos;
  logic [psc_pkg::MODE_W-1:0] next_mode;

  always_comb begin
    if (cfg.mode_count == 4'd0) begin
      mode_eff = 4'd1;
    end else if (int'(cfg.mode_count) > MODES) begin
      mode_eff = 4'(MODES);
    end else begin
      mode_eff = cfg.mode_count;
    end
  end

  assign line_wrap = (scan_r.line_number == '1);

  always_comb begin
    mode_pos = '0;
    for (int k = 0; k < MODES; k++) begin
      if (line_wrap || mod_cnt_r[k] == psc_pkg::MPOS_W'(k)) begin
        mod_cnt_inc[k] = '0;
      end else begin
        mod_cnt_inc[k] = mod_cnt_r[k] + psc_pkg::MPOS_W'(1);
      end
      if (mode_eff == 4'(k + 1)) begin
        mode_pos = mod_cnt_inc[k];
      end
    end
  end

  assign next_mode = cfg.mode_list[{mode_pos, 2'b00} +: psc_pkg::MODE_W];

  always_comb begin
    scan_nxt    = scan_r;
    record_nxt  = record_r;
    mod_cnt_nxt = mod_cnt_r;
    if (rec_fire) begin
      record_nxt = record_r + psc_pkg::TIME_W'(1);
      unique case (rec_channel)
        psc_pkg::CH_LINE_START: begin
          scan_nxt.scanning        = 1'b1;
          scan_nxt.line_start_time = rec_time;
        end
        psc_pkg::CH_LINE_END: begin
          scan_nxt.scanning    = 1'b0;
          scan_nxt.line_number = scan_r.line_number + psc_pkg::LINE_W'(1);
          scan_nxt.active_mode = next_mode;
          mod_cnt_nxt          = mod_cnt_inc;
        end
        psc_pkg::CH_FRAME: begin
          scan_nxt.frame_number = scan_r.frame_number + psc_pkg::FRAME_W'(1);
          scan_nxt.line_number  = '0;
          for (int k = 0; k < MODES; k++) begin
            mod_cnt_nxt[k] = '0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_r   <= '0;
      record_r <= '0;
      for (int k = 0; k < MODES; k++) begin
        mod_cnt_r[k] <= '0;
      end
    end else begin
      scan_r    <= scan_nxt;
      record_r  <= record_nxt;
      mod_cnt_r <= mod_cnt_nxt;
    end
  end

  assign scan   = scan_r;
  assign record = record_r;

endmodule

`default_nettype wire

// ===== rtl/psc_slot_table.sv =====
`default_nettype none

module psc_slot_table #(
  parameter int SLOTS = 8
) (
  input  wire logic                         clk,
  input  wire logic                         wr_en,
  input  wire logic [psc_pkg::SLOT_W-1:0]   wr_index,
  input  wire psc_pkg::slot_entry_t         wr_entry,
  input  wire logic [psc_pkg::TAC_W-1:0]    tac,
  input  wire logic [psc_pkg::TIME_W-1:0]   rec_time,
  input  wire logic [psc_pkg::CH_W-1:0]     channel,
  input  wire logic [psc_pkg::MODE_W-1:0]   mode,
  input  wire logic [3:0]                   slots_in_use,
  output logic                              hit,
  output logic [psc_pkg::SLOT_W-1:0]        slot
);

  psc_pkg::slot_entry_t entry_r [SLOTS];
  logic [SLOTS-1:0] match;

  // Writes to an index beyond the table fall through every compare and are dropped.
  always_ff @(posedge clk) begin
    for (int k = 0; k < SLOTS; k++) begin
      if (wr_en && int'(wr_index) == k) begin
        entry_r[k] <= wr_entry;
      end
    end
  end

  always_comb begin
    for (int k = 0; k < SLOTS; k++) begin
      match[k] = (k < int'(slots_in_use))
              && (tac > entry_r[k].tac_low) && (tac < entry_r[k].tac_high)
              && (rec_time > entry_r[k].time_low) && (rec_time < entry_r[k].time_high)
              && !channel[psc_pkg::CH_W-1] && entry_r[k].routes[channel[5:0]]
              && (entry_r[k].mode == mode);
    end
  end

  // The lowest matching slot wins.
  always_comb begin
    hit  = |match;
    slot = '0;
    for (int k = SLOTS - 1; k >= 0; k--) begin
      if (match[k]) begin
        slot = psc_pkg::SLOT_W'(k);
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/psc_pos_calc.sv =====
`default_nettype none

module psc_pos_calc (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       req_valid,
  output logic                            req_ready,
  input  wire psc_pkg::pos_req_t          req,
  input  wire logic [psc_pkg::CFG_W-1:0]  pos_scale,
  input  wire logic [psc_pkg::CFG_W-1:0]  line_step,
  psc_out_if.source                       out_ch
);

  typedef struct packed {
    psc_pkg::pos_req_t req;
    logic [47:0]       hs;
    logic [63:0]       ls;
    logic [47:0]       yp;
  } prod_t;

  typedef struct packed {
    logic [psc_pkg::SLOT_W-1:0]  slot;
    logic [psc_pkg::TAC_W-1:0]   tac;
    logic [psc_pkg::TIME_W-1:0]  rec_time;
    logic [psc_pkg::CH_W-1:0]    channel;
    logic [psc_pkg::TIME_W-1:0]  record;
    logic [psc_pkg::POS_W-1:0]   x_pos;
    logic [psc_pkg::POS_W-1:0]   y_pos;
    logic [psc_pkg::FRAME_W-1:0] frame;
  } res_t;

  logic  p2_v_r, p2_v_nxt;
  prod_t p2_r, p2_nxt;
  logic  out_v_r, out_v_nxt;
  res_t  out_r, out_nxt;
  logic  p3_ready;

  logic        x_sat;
  logic [40:0] x_sum;

  assign p3_ready  = !out_v_r || out_ch.ready;
  assign req_ready = !p2_v_r || p3_ready;

  // Stage two: the 48-bit distance is split into a 16-bit and a 32-bit part.
  always_comb begin
    p2_nxt.req = req;
    p2_nxt.hs  = 48'(req.diff[47:32]) * 48'(pos_scale);
    p2_nxt.ls  = 64'(req.diff[31:0]) * 64'(pos_scale);
    p2_nxt.yp  = 48'(req.line_number) * 48'(line_step);
    p2_v_nxt   = req_ready ? req_valid : p2_v_r;
  end

  // Stage three: recombine the partial products and saturate to Q16.16; x is zero before the line start.
  always_comb begin
    x_sat = (p2_r.hs[47:8] != '0) || (p2_r.ls[63:40] != '0);
    x_sum = {1'b0, p2_r.hs[7:0], 32'h0} + {1'b0, p2_r.ls[39:0]};

    out_nxt.slot     = p2_r.req.slot;
    out_nxt.tac      = p2_r.req.tac;
    out_nxt.rec_time = p2_r.req.rec_time;
    out_nxt.channel  = p2_r.req.channel;
    out_nxt.record   = p2_r.req.record;
    out_nxt.frame    = p2_r.req.frame;
    if (p2_r.req.before_start) begin
      out_nxt.x_pos = '0;
    end else if (x_sat || x_sum[40]) begin
      out_nxt.x_pos = '1;
    end else begin
      out_nxt.x_pos = x_sum[39:8];
    end
    out_nxt.y_pos = (p2_r.yp[47:32] != '0) ? '1 : p2_r.yp[31:0];
    out_v_nxt     = p3_ready ? p2_v_r : out_v_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p2_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      p2_v_r  <= p2_v_nxt;
      out_v_r <= out_v_nxt;
    end
    if (req_valid && req_ready) begin
      p2_r <= p2_nxt;
    end
    if (p2_v_r && p3_ready) begin
      out_r <= out_nxt;
    end
  end

  assign out_ch.valid       = out_v_r;
  assign out_ch.out_slot    = out_r.slot;
  assign out_ch.out_tac     = out_r.tac;
  assign out_ch.out_time    = out_r.rec_time;
  assign out_ch.out_channel = out_r.channel;
  assign out_ch.out_record  = out_r.record;
  assign out_ch.x_pos       = out_r.x_pos;
  assign out_ch.y_pos       = out_r.y_pos;
  assign out_ch.out_frame   = out_r.frame;

endmodule

`default_nettype wire

// ===== rtl/photon_scan_channel_sorter.sv =====
// Throughput: one item per cycle unless out_ch.ready stalls the output; the slot
// compares and priority pick run in the accept cycle and load s1_r, the position
// multipliers feed p2_r and the saturation feeds the output register out_r.
// Reset is synchronous and active low: it clears the scan state, counters and
// pipeline valids and loads the register defaults; the slot table is not cleared.
`default_nettype none

module photon_scan_channel_sorter #(
  parameter int SLOTS     = 8,
  parameter int MODES     = 8,
  parameter int TIME_BITS = 48
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  psc_in_if.sink                                in_ch,
  psc_out_if.source                             out_ch,
  input  wire logic                             cfg_we,
  input  wire logic [psc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [psc_pkg::CFG_W-1:0]        cfg_wdata
);

  localparam int TB = (TIME_BITS < psc_pkg::TIME_W) ? TIME_BITS : psc_pkg::TIME_W;
  localparam logic [psc_pkg::TIME_W-1:0] TIME_MASK =
      (psc_pkg::TIME_W'(1) << TB) - psc_pkg::TIME_W'(1);

  psc_pkg::cfg_t cfg_r, cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (psc_pkg::cfg_idx_t'(cfg_index))
        psc_pkg::CFG_SLOTS_IN_USE: cfg_nxt.slots_in_use = cfg_wdata[3:0];
        psc_pkg::CFG_MODE_COUNT:   cfg_nxt.mode_count   = cfg_wdata[3:0];
        psc_pkg::CFG_MODE_LIST:    cfg_nxt.mode_list    = cfg_wdata;
        psc_pkg::CFG_POS_SCALE:    cfg_nxt.pos_scale    = cfg_wdata;
        psc_pkg::CFG_LINE_STEP:    cfg_nxt.line_step    = cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  logic                            accept;
  logic                            rec_fire;
  logic                            is_marker;
  logic [psc_pkg::TIME_W-1:0]      rec_t;
  psc_pkg::slot_entry_t            wr_entry;
  psc_pkg::scan_t                  scan;
  logic [psc_pkg::TIME_W-1:0]      record;
  logic                            tbl_hit;
  logic [psc_pkg::SLOT_W-1:0]      tbl_slot;
  logic                            photon_hit;

  logic              s1_v_r, s1_v_nxt;
  psc_pkg::pos_req_t s1_r, s1_nxt;
  logic              s1_ready;

  assign accept    = in_ch.valid && in_ch.ready;
  assign rec_fire  = accept && !in_ch.func;
  assign rec_t     = in_ch.rec_time & TIME_MASK;
  assign is_marker = (in_ch.rec_channel == psc_pkg::CH_LINE_START)
                  || (in_ch.rec_channel == psc_pkg::CH_LINE_END)
                  || (in_ch.rec_channel == psc_pkg::CH_FRAME);

  always_comb begin
    wr_entry.tac_low   = in_ch.new_tac_min;
    wr_entry.tac_high  = in_ch.new_tac_max;
    wr_entry.time_low  = in_ch.new_time_min & TIME_MASK;
    wr_entry.time_high = in_ch.new_time_max & TIME_MASK;
    wr_entry.mode      = in_ch.new_mode_id;
    wr_entry.routes    = in_ch.new_route_mask;
  end

  psc_scan_state #(
    .MODES (MODES)
  ) u_scan (
    .clk         (clk),
    .rst_n       (rst_n),
    .rec_fire    (rec_fire),
    .rec_channel (in_ch.rec_channel),
    .rec_time    (rec_t),
    .cfg         (cfg_r),
    .scan        (scan),
    .record      (record)
  );

  psc_slot_table #(
    .SLOTS (SLOTS)
  ) u_table (
    .clk          (clk),
    .wr_en        (accept && in_ch.func),
    .wr_index     (in_ch.slot_index),
    .wr_entry     (wr_entry),
    .tac          (in_ch.rec_tac),
    .rec_time     (rec_t),
    .channel      (in_ch.rec_channel),
    .mode         (scan.active_mode),
    .slots_in_use (cfg_r.slots_in_use),
    .hit          (tbl_hit),
    .slot         (tbl_slot)
  );

  // Markers update the scan state and never produce a result.
  assign photon_hit = rec_fire && !is_marker && scan.scanning && tbl_hit;

  always_comb begin
    s1_nxt.slot         = tbl_slot;
    s1_nxt.tac          = in_ch.rec_tac;
    s1_nxt.rec_time     = rec_t;
    s1_nxt.channel      = in_ch.rec_channel;
    s1_nxt.record       = record;
    s1_nxt.diff         = rec_t - scan.line_start_time;
    s1_nxt.before_start = rec_t < scan.line_start_time;
    s1_nxt.line_number  = scan.line_number;
    s1_nxt.frame        = scan.frame_number;
    if (accept) begin
      s1_v_nxt = photon_hit;
    end else if (s1_ready) begin
      s1_v_nxt = 1'b0;
    end else begin
      s1_v_nxt = s1_v_r;
    end
  end

  assign in_ch.ready = !s1_v_r || s1_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r             <= 1'b0;
      cfg_r.slots_in_use <= 4'd0;
      cfg_r.mode_count   <= 4'd1;
      cfg_r.mode_list    <= 32'h0000_0000;
      cfg_r.pos_scale    <= 32'h0100_0000;
      cfg_r.line_step    <= 32'h0001_0000;
    end else begin
      s1_v_r <= s1_v_nxt;
      cfg_r  <= cfg_nxt;
    end
    if (photon_hit) begin
      s1_r <= s1_nxt;
    end
  end

  psc_pos_calc u_pos (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (s1_v_r),
    .req_ready (s1_ready),
    .req       (s1_r),
    .pos_scale (cfg_r.pos_scale),
    .line_step (cfg_r.line_step),
    .out_ch    (out_ch)
  );

endmodule

`default_nettype wire
